### sv/msx_pkg.sv
// Shared types and constants of the mask outline segment extractor.
// Used by every module of the block but msx_ram; no dependencies of its own.
`default_nettype none

package msx_pkg;

   localparam int COORD_W    = 13;
   localparam int SAMPLE_W   = 16;
   localparam int SIZE_W     = 13;
   localparam int TILE_COL_W = 4;
   localparam int TILE_ROW_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int SIZE_RST = 4096;
   localparam logic [SAMPLE_W-1:0] THRESH_RST = 16'h8000;

   localparam int QUEUE_DEPTH = 4;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_COLUMN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_ROW    = 3'd4;

   typedef struct packed {
      logic [COORD_W-1:0] from_x;
      logic [COORD_W-1:0] from_y;
      logic [COORD_W-1:0] to_x;
      logic [COORD_W-1:0] to_y;
   } seg_type;

   // all segments caused by one grid position
   typedef struct packed {
      logic                  h_valid;
      logic                  v_valid;
      seg_type               h_seg;
      seg_type               v_seg;
      logic [TILE_COL_W-1:0] tile_column;
      logic [TILE_ROW_W-1:0] tile_row;
      logic                  end_tile;
   } bundle_type;

   typedef struct packed {
      logic row_open;
      logic at_origin;
      logic pos_in_range;
   } status_type;

endpackage

`default_nettype wire

### sv/msx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module msx_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4097
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### sv/msx_front.sv
// Front end: configuration registers, scan position, column state RAM and edge
// classification. Emits a bundle per position that has segments. Depends on msx_pkg, msx_ram.
`default_nettype none

module msx_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_fire,
   input  wire logic [msx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [msx_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                               accept,
   input  wire logic [msx_pkg::SAMPLE_W-1:0]       sample,
   output logic                                    push,
   output msx_pkg::bundle_type                     bundle,
   output msx_pkg::status_type                     status
);

   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int YW    = $clog2(MAX_HEIGHT + 1);
   localparam int RAM_W = YW + 3;
   localparam int W_RST = (MAX_WIDTH < msx_pkg::SIZE_RST) ? MAX_WIDTH : msx_pkg::SIZE_RST;
   localparam int H_RST = (MAX_HEIGHT < msx_pkg::SIZE_RST) ? MAX_HEIGHT : msx_pkg::SIZE_RST;

   logic [XW-1:0]                     w_ff, w_in;
   logic [YW-1:0]                     h_ff, h_in;
   logic [msx_pkg::SAMPLE_W-1:0]      thr_ff, thr_in;
   logic [msx_pkg::TILE_COL_W-1:0]    tcol_ff, tcol_in;
   logic [msx_pkg::TILE_ROW_W-1:0]    trow_ff, trow_in;
   logic [XW-1:0]                     pos_x_ff, pos_x_in;
   logic [YW-1:0]                     pos_y_ff, pos_y_in;
   logic                              left_ff, left_in;
   logic                              row_open_ff, row_open_in;
   logic [XW-1:0]                     row_start_ff, row_start_in;
   logic                              row_type_ff, row_type_in;

   logic [RAM_W-1:0] q;
   logic [RAM_W-1:0] wdata;
   logic             q_prev, q_open, q_type;
   logic [YW-1:0]    q_start;
   logic             restart;
   logic             x_in_mask, y_in_mask, sel, top, hedge, left, vedge, v_open;
   logic             h_emit, v_emit;
   logic [msx_pkg::SIZE_W-1:0] size_val;

   assign q_prev  = q[RAM_W-1];
   assign q_open  = q[RAM_W-2];
   assign q_type  = q[RAM_W-3];
   assign q_start = q[YW-1:0];

   assign size_val = csr_wdata[msx_pkg::SIZE_W-1:0];

   // classify the boundaries owned by the current position
   always_comb begin
      x_in_mask = pos_x_ff < w_ff;
      y_in_mask = pos_y_ff < h_ff;
      sel       = x_in_mask && y_in_mask && (sample > thr_ff);
      top       = (pos_y_ff != '0) && q_prev;
      hedge     = x_in_mask && (top != sel);
      h_emit    = row_open_ff && (hedge ? (row_type_ff != sel) : 1'b1);
      left      = (pos_x_ff != '0) && left_ff;
      vedge     = y_in_mask && (left != sel);
      // column state is stale on the first row of a scan
      v_open    = (pos_y_ff != '0) && q_open;
      v_emit    = v_open && (vedge ? (q_type != sel) : 1'b1);
   end

   always_comb begin
      bundle.h_valid      = h_emit;
      bundle.v_valid      = v_emit;
      bundle.h_seg.from_y = msx_pkg::COORD_W'(pos_y_ff);
      bundle.h_seg.to_y   = msx_pkg::COORD_W'(pos_y_ff);
      bundle.h_seg.from_x = row_type_ff ? msx_pkg::COORD_W'(pos_x_ff)
                                        : msx_pkg::COORD_W'(row_start_ff);
      bundle.h_seg.to_x   = row_type_ff ? msx_pkg::COORD_W'(row_start_ff)
                                        : msx_pkg::COORD_W'(pos_x_ff);
      bundle.v_seg.from_x = msx_pkg::COORD_W'(pos_x_ff);
      bundle.v_seg.to_x   = msx_pkg::COORD_W'(pos_x_ff);
      bundle.v_seg.from_y = q_type ? msx_pkg::COORD_W'(q_start)
                                   : msx_pkg::COORD_W'(pos_y_ff);
      bundle.v_seg.to_y   = q_type ? msx_pkg::COORD_W'(pos_y_ff)
                                   : msx_pkg::COORD_W'(q_start);
      bundle.tile_column  = tcol_ff;
      bundle.tile_row     = trow_ff;
      bundle.end_tile     = (pos_x_ff == w_ff) && (pos_y_ff == h_ff);
   end

   assign push = accept && (h_emit || v_emit);

   // updated column word
   always_comb begin
      wdata = q;
      wdata[RAM_W-1] = sel;
      wdata[RAM_W-2] = vedge;
      if (vedge && (!v_open || (q_type != sel))) begin
         wdata[RAM_W-3]  = sel;
         wdata[YW-1:0]   = pos_y_ff;
      end
   end

   always_comb begin
      w_in         = w_ff;
      h_in         = h_ff;
      thr_in       = thr_ff;
      tcol_in      = tcol_ff;
      trow_in      = trow_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      left_in      = left_ff;
      row_open_in  = row_open_ff;
      row_start_in = row_start_ff;
      row_type_in  = row_type_ff;
      restart      = 1'b0;

      if (csr_fire) begin
         unique case (csr_index)
            msx_pkg::CSR_MASK_WIDTH: begin
               restart = 1'b1;
               if (size_val == '0) begin
                  w_in = XW'(1);
               end else if (32'(size_val) > MAX_WIDTH) begin
                  w_in = XW'(MAX_WIDTH);
               end else begin
                  w_in = XW'(size_val);
               end
            end
            msx_pkg::CSR_MASK_HEIGHT: begin
               restart = 1'b1;
               if (size_val == '0) begin
                  h_in = YW'(1);
               end else if (32'(size_val) > MAX_HEIGHT) begin
                  h_in = YW'(MAX_HEIGHT);
               end else begin
                  h_in = YW'(size_val);
               end
            end
            msx_pkg::CSR_THRESHOLD:   thr_in  = csr_wdata;
            msx_pkg::CSR_TILE_COLUMN: tcol_in = csr_wdata[msx_pkg::TILE_COL_W-1:0];
            msx_pkg::CSR_TILE_ROW:    trow_in = csr_wdata[msx_pkg::TILE_ROW_W-1:0];
            default: ;
         endcase
      end

      if (restart) begin
         pos_x_in     = '0;
         pos_y_in     = '0;
         left_in      = 1'b0;
         row_open_in  = 1'b0;
         row_start_in = '0;
         row_type_in  = 1'b0;
      end else if (accept) begin
         if (hedge) begin
            row_open_in = 1'b1;
            if (!row_open_ff || (row_type_ff != sel)) begin
               row_start_in = pos_x_ff;
               row_type_in  = sel;
            end
         end else begin
            row_open_in = 1'b0;
         end
         left_in = x_in_mask && sel;
         // advance in raster order, wrap after the last grid position
         if (!x_in_mask) begin
            pos_x_in = '0;
            pos_y_in = y_in_mask ? (pos_y_ff + YW'(1)) : '0;
         end else begin
            pos_x_in = pos_x_ff + XW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff         <= XW'(W_RST);
         h_ff         <= YW'(H_RST);
         thr_ff       <= msx_pkg::THRESH_RST;
         tcol_ff      <= '0;
         trow_ff      <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         left_ff      <= 1'b0;
         row_open_ff  <= 1'b0;
         row_start_ff <= '0;
         row_type_ff  <= 1'b0;
      end else begin
         w_ff         <= w_in;
         h_ff         <= h_in;
         thr_ff       <= thr_in;
         tcol_ff      <= tcol_in;
         trow_ff      <= trow_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         left_ff      <= left_in;
         row_open_ff  <= row_open_in;
         row_start_ff <= row_start_in;
         row_type_ff  <= row_type_in;
      end
   end

   // read ahead at the next position so its word is ready when it arrives
   msx_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_WIDTH + 1)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pos_x_ff),
      .wr_data (wdata),
      .rd_addr (pos_x_in),
      .rd_data (q)
   );

   always_comb begin
      status.row_open     = row_open_ff;
      status.at_origin    = (pos_x_ff == '0) && (pos_y_ff == '0);
      status.pos_in_range = (pos_x_ff <= w_ff) && (pos_y_ff <= h_ff);
   end

endmodule

`default_nettype wire

### sv/msx_queue.sv
// Short FIFO of segment bundles between front and back end.
// Depends on msx_pkg.
`default_nettype none

module msx_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire msx_pkg::bundle_type push_data,
   input  wire logic                pop,
   output msx_pkg::bundle_type      head,
   output logic                     empty,
   output logic                     full
);

   localparam int PTR_W = (msx_pkg::QUEUE_DEPTH > 1) ? $clog2(msx_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(msx_pkg::QUEUE_DEPTH + 1);

   msx_pkg::bundle_type entry_ff [msx_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(msx_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign head  = entry_ff[rd_ptr_ff];
   assign empty = count_ff == '0;
   assign full  = count_ff == CNT_W'(msx_pkg::QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### sv/msx_back.sv
// Back end: takes bundles from the queue and sends their segments one item
// per cycle while rsp_stall is low, horizontal before vertical. Depends on msx_pkg.
`default_nettype none

module msx_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_empty,
   input  wire msx_pkg::bundle_type           q_head,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output msx_pkg::seg_type                   rsp_seg,
   output logic                               rsp_is_vertical,
   output logic [msx_pkg::TILE_COL_W-1:0]     rsp_tile_column,
   output logic [msx_pkg::TILE_ROW_W-1:0]     rsp_tile_row,
   output logic                               rsp_last_of_item,
   output logic                               rsp_last_of_tile
);

   msx_pkg::bundle_type cur_ff, cur_in;
   logic h_pend_ff, h_pend_in;
   logic v_pend_ff, v_pend_in;
   logic take, done;

   assign rsp_valid = h_pend_ff || v_pend_ff;
   assign take      = rsp_valid && !rsp_stall;
   assign done      = take && !(h_pend_ff && v_pend_ff);
   assign q_pop     = (!rsp_valid || done) && !q_empty;

   always_comb begin
      cur_in    = cur_ff;
      h_pend_in = h_pend_ff;
      v_pend_in = v_pend_ff;
      if (q_pop) begin
         cur_in    = q_head;
         h_pend_in = q_head.h_valid;
         v_pend_in = q_head.v_valid;
      end else if (done) begin
         h_pend_in = 1'b0;
         v_pend_in = 1'b0;
      end else if (take) begin
         // horizontal segment gone, vertical one follows
         h_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_pend_ff <= 1'b0;
         v_pend_ff <= 1'b0;
      end else begin
         h_pend_ff <= h_pend_in;
         v_pend_ff <= v_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_seg          = h_pend_ff ? cur_ff.h_seg : cur_ff.v_seg;
   assign rsp_is_vertical  = !h_pend_ff;
   assign rsp_tile_column  = cur_ff.tile_column;
   assign rsp_tile_row     = cur_ff.tile_row;
   assign rsp_last_of_item = !(h_pend_ff && v_pend_ff);
   assign rsp_last_of_tile = cur_ff.end_tile;

endmodule

`default_nettype wire

### sv/mask_outline_segment_extractor.sv
// Mask outline segment extractor, top level.
// Depends on msx_pkg, msx_front, msx_queue, msx_back, msx_ram.
//
// Usage:
//   req channel: one mask sample per grid position, raster order over the
//   (width+1) by (height+1) grid; the sample at a virtual position is ignored.
//   rsp channel: zero, one or two segments per position, horizontal first;
//   last_of_item marks the last segment of a position, last_of_tile is set
//   on segments of the final grid position. After it the scan wraps to (0,0).
//   csr channel: register writes, always ready. Write only while idle.
//   A size write restarts the scan and drops every open run.
// Timing:
//   One position accepted per clock while req_stall is low. A position's
//   segments pass the queue and then the output register before they show on rsp.
//   The rsp side sends one segment per clock while rsp_stall is low,
//   so a position with two segments holds the output stage for both; a four-entry
//   queue between classifier and output stage absorbs that.
//   The per-column run state lives in one RAM read one position ahead,
//   which sets the one-position-per-clock rate.
// Reset clears the scan position and the row run state; the column RAM is not
// cleared, and no clearing pass is needed. When rsp_stall is high the output holds
// and the queue fills; req_stall rises once the queue is full.
`default_nettype none

module mask_outline_segment_extractor #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [msx_pkg::SAMPLE_W-1:0]       req_sample,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [msx_pkg::COORD_W-1:0]             rsp_from_x,
   output logic [msx_pkg::COORD_W-1:0]             rsp_from_y,
   output logic [msx_pkg::COORD_W-1:0]             rsp_to_x,
   output logic [msx_pkg::COORD_W-1:0]             rsp_to_y,
   output logic                                    rsp_is_vertical,
   output logic [msx_pkg::TILE_COL_W-1:0]          rsp_seg_tile_column,
   output logic [msx_pkg::TILE_ROW_W-1:0]          rsp_seg_tile_row,
   output logic                                    rsp_last_of_item,
   output logic                                    rsp_last_of_tile,

   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [msx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [msx_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                accept;
   logic                q_push;
   logic                q_pop;
   logic                q_empty;
   logic                q_full;
   msx_pkg::bundle_type push_bundle;
   msx_pkg::bundle_type q_head;
   msx_pkg::seg_type    seg;
   msx_pkg::status_type st;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   msx_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_fire  (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .sample    (req_sample),
      .push      (q_push),
      .bundle    (push_bundle),
      .status    (st)
   );

   msx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_bundle),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   msx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_seg          (seg),
      .rsp_is_vertical  (rsp_is_vertical),
      .rsp_tile_column  (rsp_seg_tile_column),
      .rsp_tile_row     (rsp_seg_tile_row),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_last_of_tile (rsp_last_of_tile)
   );

   assign rsp_from_x = seg.from_x;
   assign rsp_from_y = seg.from_y;
   assign rsp_to_x   = seg.to_x;
   assign rsp_to_y   = seg.to_y;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("bundle pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("bundle popped from empty queue");

   a_row_closed_at_origin: assert property (@(posedge clock) disable iff (reset)
      st.at_origin |-> !st.row_open)
      else $error("horizontal run open at scan start");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      st.pos_in_range)
      else $error("scan position beyond grid");

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for mask_outline_segment_extractor.
// Depends on msx_pkg and the block's RTL; predicts segments per grid position
// and checks each rsp item against the oldest expected segment.
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_WIDTH    = 4096;
   localparam int MAX_HEIGHT   = 4096;
   localparam int IDLE_PCT     = 13;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct {
      logic [msx_pkg::COORD_W-1:0]    from_x;
      logic [msx_pkg::COORD_W-1:0]    from_y;
      logic [msx_pkg::COORD_W-1:0]    to_x;
      logic [msx_pkg::COORD_W-1:0]    to_y;
      logic                           is_vertical;
      logic [msx_pkg::TILE_COL_W-1:0] tile_column;
      logic [msx_pkg::TILE_ROW_W-1:0] tile_row;
      logic                           last_of_item;
      logic                           last_of_tile;
   } outline_segment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [msx_pkg::SAMPLE_W-1:0]   req_sample = '0;

   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [msx_pkg::COORD_W-1:0]    rsp_from_x;
   logic [msx_pkg::COORD_W-1:0]    rsp_from_y;
   logic [msx_pkg::COORD_W-1:0]    rsp_to_x;
   logic [msx_pkg::COORD_W-1:0]    rsp_to_y;
   logic                           rsp_is_vertical;
   logic [msx_pkg::TILE_COL_W-1:0] rsp_seg_tile_column;
   logic [msx_pkg::TILE_ROW_W-1:0] rsp_seg_tile_row;
   logic                           rsp_last_of_item;
   logic                           rsp_last_of_tile;

   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [msx_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [msx_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   mask_outline_segment_extractor uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_from_x(rsp_from_x),
      .rsp_from_y(rsp_from_y),
      .rsp_to_x(rsp_to_x),
      .rsp_to_y(rsp_to_y),
      .rsp_is_vertical(rsp_is_vertical),
      .rsp_seg_tile_column(rsp_seg_tile_column),
      .rsp_seg_tile_row(rsp_seg_tile_row),
      .rsp_last_of_item(rsp_last_of_item),
      .rsp_last_of_tile(rsp_last_of_tile),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   logic [msx_pkg::SIZE_W-1:0]     reg_width;
   logic [msx_pkg::SIZE_W-1:0]     reg_height;
   logic [msx_pkg::SAMPLE_W-1:0]   reg_threshold;
   logic [msx_pkg::TILE_COL_W-1:0] reg_tile_column;
   logic [msx_pkg::TILE_ROW_W-1:0] reg_tile_row;

   bit                             prev_row_sel [MAX_WIDTH];
   bit                             col_open     [MAX_WIDTH+1];
   logic [msx_pkg::COORD_W-1:0]    col_start    [MAX_WIDTH+1];
   bit                             col_type     [MAX_WIDTH+1];
   bit                             row_open;
   logic [msx_pkg::COORD_W-1:0]    row_start;
   bit                             row_type;
   bit                             left_neighbor_sel;
   int unsigned                    scan_x;
   int unsigned                    scan_y;

   outline_segment_type            expected_segments [$];
   outline_segment_type            head_seg;
   int unsigned                    mismatches = 0;
   int unsigned                    items_pushed = 0;
   int unsigned                    items_accepted = 0;
   int unsigned                    cycle_count = 0;
   bit                             steady = 1'b0;
   logic [msx_pkg::SAMPLE_W-1:0]   pending_samples [$];

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned limit);
      if (v < 1) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   task automatic restart_scan();
      foreach (col_open[i]) col_open[i] = 1'b0;
      row_open          = 1'b0;
      row_start         = '0;
      row_type          = 1'b0;
      left_neighbor_sel = 1'b0;
      scan_x            = 0;
      scan_y            = 0;
   endtask

   task automatic apply_register(input logic [msx_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [msx_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         msx_pkg::CSR_MASK_WIDTH: begin
            reg_width = data[msx_pkg::SIZE_W-1:0];
            restart_scan();
         end
         msx_pkg::CSR_MASK_HEIGHT: begin
            reg_height = data[msx_pkg::SIZE_W-1:0];
            restart_scan();
         end
         msx_pkg::CSR_THRESHOLD:   reg_threshold   = data[msx_pkg::SAMPLE_W-1:0];
         msx_pkg::CSR_TILE_COLUMN: reg_tile_column = data[msx_pkg::TILE_COL_W-1:0];
         msx_pkg::CSR_TILE_ROW:    reg_tile_row    = data[msx_pkg::TILE_ROW_W-1:0];
         default: ;
      endcase
   endtask

   // endpoints swap when the run's winding is reversed
   function automatic outline_segment_type make_segment(
         input logic [msx_pkg::COORD_W-1:0] ax, input logic [msx_pkg::COORD_W-1:0] ay,
         input logic [msx_pkg::COORD_W-1:0] bx, input logic [msx_pkg::COORD_W-1:0] by,
         input bit reversed, input bit vertical);
      outline_segment_type s;
      s.from_x       = reversed ? bx : ax;
      s.from_y       = reversed ? by : ay;
      s.to_x         = reversed ? ax : bx;
      s.to_y         = reversed ? ay : by;
      s.is_vertical  = vertical;
      s.tile_column  = reg_tile_column;
      s.tile_row     = reg_tile_row;
      s.last_of_item = 1'b0;
      s.last_of_tile = 1'b0;
      return s;
   endfunction

   task automatic predict_position(input logic [msx_pkg::SAMPLE_W-1:0] sample_value);
      int unsigned                 w, h, x, y;
      logic [msx_pkg::COORD_W-1:0] cx, cy;
      bit                          sel, above, left_side, is_edge, end_tile;
      outline_segment_type         found [$];
      w  = clamp_size(32'(reg_width), MAX_WIDTH);
      h  = clamp_size(32'(reg_height), MAX_HEIGHT);
      x  = scan_x;
      y  = scan_y;
      cx = msx_pkg::COORD_W'(x);
      cy = msx_pkg::COORD_W'(y);
      sel = (x < w) && (y < h) && (sample_value > reg_threshold);

      // horizontal boundary on row y
      is_edge = 1'b0;
      if (x < w) begin
         above = (y > 0) && prev_row_sel[x];
         is_edge = (above != sel);
      end
      if (is_edge) begin
         if (!row_open) begin
            row_open  = 1'b1;
            row_start = cx;
            row_type  = sel;
         end else if (row_type != sel) begin
            found.push_back(make_segment(row_start, cy, cx, cy, row_type, 1'b0));
            row_start = cx;
            row_type  = sel;
         end
      end else if (row_open) begin
         found.push_back(make_segment(row_start, cy, cx, cy, row_type, 1'b0));
         row_open = 1'b0;
      end

      // vertical boundary on column x
      is_edge = 1'b0;
      if (y < h) begin
         left_side = (x > 0) && left_neighbor_sel;
         is_edge = (left_side != sel);
      end
      if (is_edge) begin
         if (!col_open[x]) begin
            col_open[x]  = 1'b1;
            col_start[x] = cy;
            col_type[x]  = sel;
         end else if (col_type[x] != sel) begin
            found.push_back(make_segment(cx, col_start[x], cx, cy, !col_type[x], 1'b1));
            col_start[x] = cy;
            col_type[x]  = sel;
         end
      end else if (col_open[x]) begin
         found.push_back(make_segment(cx, col_start[x], cx, cy, !col_type[x], 1'b1));
         col_open[x] = 1'b0;
      end

      if (x < w) prev_row_sel[x] = sel;
      left_neighbor_sel = (x < w) ? sel : 1'b0;

      end_tile = (x == w) && (y == h);
      foreach (found[i]) begin
         found[i].last_of_item = (i == found.size() - 1);
         found[i].last_of_tile = end_tile;
         expected_segments.push_back(found[i]);
      end

      // advance in raster order, wrap after the final position
      if (x >= w) begin
         scan_x = 0;
         if (y >= h) begin
            scan_y            = 0;
            left_neighbor_sel = 1'b0;
         end else begin
            scan_y = y + 1;
         end
      end else begin
         scan_x = x + 1;
      end
   endtask

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_samples.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_valid  <= 1'b1;
            req_sample <= pending_samples.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            predict_position(req_sample);
            items_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_segments.size() == 0) begin
               $display("%0t: segment (%0d,%0d)-(%0d,%0d) with none expected", $time,
                        rsp_from_x, rsp_from_y, rsp_to_x, rsp_to_y);
               mismatches++;
            end else begin
               head_seg = expected_segments.pop_front();
               compare_field("from_x", 16'(head_seg.from_x), 16'(rsp_from_x));
               compare_field("from_y", 16'(head_seg.from_y), 16'(rsp_from_y));
               compare_field("to_x", 16'(head_seg.to_x), 16'(rsp_to_x));
               compare_field("to_y", 16'(head_seg.to_y), 16'(rsp_to_y));
               compare_field("is_vertical", 16'(head_seg.is_vertical),
                             16'(rsp_is_vertical));
               compare_field("seg_tile_column", 16'(head_seg.tile_column),
                             16'(rsp_seg_tile_column));
               compare_field("seg_tile_row", 16'(head_seg.tile_row),
                             16'(rsp_seg_tile_row));
               compare_field("last_of_item", 16'(head_seg.last_of_item),
                             16'(rsp_last_of_item));
               compare_field("last_of_tile", 16'(head_seg.last_of_tile),
                             16'(rsp_last_of_tile));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   logic [msx_pkg::SAMPLE_W-1:0] stim_threshold = msx_pkg::THRESH_RST;
   int unsigned grid_size = (msx_pkg::SIZE_RST + 1) * (msx_pkg::SIZE_RST + 1);
   int unsigned grid_pos = 0;

   task automatic write_csr(input logic [msx_pkg::CSR_IDX_W-1:0] idx,
                            input logic [msx_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(input logic [msx_pkg::CSR_DATA_W-1:0] wv,
                           input logic [msx_pkg::CSR_DATA_W-1:0] hv);
      write_csr(msx_pkg::CSR_MASK_WIDTH, wv);
      write_csr(msx_pkg::CSR_MASK_HEIGHT, hv);
      grid_size = (clamp_size(32'(wv[msx_pkg::SIZE_W-1:0]), MAX_WIDTH) + 1)
                * (clamp_size(32'(hv[msx_pkg::SIZE_W-1:0]), MAX_HEIGHT) + 1);
      grid_pos = 0;
   endtask

   task automatic set_threshold(input logic [msx_pkg::SAMPLE_W-1:0] value);
      write_csr(msx_pkg::CSR_THRESHOLD, value);
      stim_threshold = value;
   endtask

   task automatic queue_sample(input logic [msx_pkg::SAMPLE_W-1:0] value);
      pending_samples.push_back(value);
      items_pushed++;
      grid_pos = (grid_pos + 1) % grid_size;
   endtask

   // density: percent of the samples not drawn at random or at the threshold that come out selected
   function automatic logic [msx_pkg::SAMPLE_W-1:0] pick_sample(
         input int unsigned density, input logic [msx_pkg::SAMPLE_W-1:0] thr);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return 16'($urandom);
      if (r < 16) return r[0] ? thr : thr + 16'd1;
      if ($urandom_range(1, 100) <= density && thr != 16'hFFFF)
         return 16'($urandom_range(32'(thr) + 1, 16'hFFFF));
      return 16'($urandom_range(0, 32'(thr)));
   endfunction

   task automatic queue_random(input int unsigned n, input int unsigned density);
      repeat (n) queue_sample(pick_sample(density, stim_threshold));
   endtask

   task automatic wait_drained();
      while (items_accepted != items_pushed || expected_segments.size() != 0)
         @(posedge clock);
   endtask

   // zero-result positions may still be in flight once the last segment is out
   task automatic wait_idle();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned random_items;
      int unsigned phase;
      int unsigned count;
      int unsigned half;
      int unsigned density;
      bit          resize;

      reg_width       = msx_pkg::SIZE_W'(msx_pkg::SIZE_RST);
      reg_height      = msx_pkg::SIZE_W'(msx_pkg::SIZE_RST);
      reg_threshold   = msx_pkg::THRESH_RST;
      reg_tile_column = '0;
      reg_tile_row    = '0;
      restart_scan();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // 3x2 mask: threshold boundary, full scale, run split where the side flips
      set_size(16'd3, 16'd2);
      set_threshold(16'h8000);
      write_csr(msx_pkg::CSR_TILE_COLUMN, 16'd12);
      write_csr(msx_pkg::CSR_TILE_ROW, 16'd255);
      queue_sample(16'h8001);
      queue_sample(16'h8000);
      queue_sample(16'hFFFF);
      queue_sample(16'hFFFF);
      queue_sample(16'h0000);
      queue_sample(16'hFFFF);
      queue_sample(16'hFFFF);
      queue_sample(16'h0000);
      queue_sample(16'hAAAA);
      queue_sample(16'h5555);
      queue_sample(16'h0000);
      queue_sample(16'hFFFF);
      wait_idle();

      // zero sizes act as one; threshold zero selects any nonzero sample
      set_size(16'd0, 16'd0);
      set_threshold(16'h0000);
      write_csr(msx_pkg::CSR_TILE_COLUMN, 16'd0);
      write_csr(msx_pkg::CSR_TILE_ROW, 16'd0);
      queue_sample(16'h0001);
      queue_sample(16'hFFFF);
      queue_sample(16'h0000);
      queue_sample(16'h0000);
      queue_sample(16'h0000);
      queue_sample(16'h0000);
      queue_sample(16'h0000);
      queue_sample(16'h0000);
      wait_idle();

      // change the threshold mid-tile, then resize mid-tile to drop open runs
      set_size(16'd4, 16'd3);
      set_threshold(16'hFFFF);
      queue_sample(16'hFFFF);
      queue_sample(16'hFFFF);
      queue_sample(16'hFFFF);
      wait_idle();
      set_threshold(16'd100);
      queue_sample(16'd101);
      queue_sample(16'd101);
      queue_sample(16'd100);
      queue_sample(16'd0);
      queue_sample(16'hFFFF);
      wait_idle();
      set_size(16'd2, 16'd2);
      queue_random(grid_size, 50);
      wait_idle();

      // start of the widest row with no idling, then of the tallest column
      steady = 1'b1;
      set_size(16'h1FFF, 16'd0);
      set_threshold(16'($urandom));
      write_csr(msx_pkg::CSR_TILE_COLUMN, 16'd9);
      queue_random(150, 60);
      wait_idle();
      steady = 1'b0;
      set_size(16'd1, 16'h1000);
      set_threshold(16'h8000);
      queue_random(100, 70);
      wait_idle();

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         resize = (phase == 0) || ($urandom_range(0, 99) < 70);
         if (resize) set_size(16'($urandom_range(1, 10)), 16'($urandom_range(1, 8)));
         if (!resize || $urandom_range(0, 99) < 60) begin
            case ($urandom_range(0, 5))
               0:       set_threshold(16'h0000);
               1:       set_threshold(16'hFFFF);
               2:       set_threshold(16'h8000);
               default: set_threshold(16'($urandom));
            endcase
         end
         if ($urandom_range(0, 99) < 40)
            write_csr(msx_pkg::CSR_TILE_COLUMN, 16'($urandom_range(0, 15)));
         if ($urandom_range(0, 99) < 40)
            write_csr(msx_pkg::CSR_TILE_ROW, 16'($urandom_range(0, 255)));

         case ($urandom_range(0, 3))
            0:       density = $urandom_range(0, 10);
            1:       density = $urandom_range(90, 100);
            default: density = $urandom_range(20, 80);
         endcase

         // mostly finish whole tiles; sometimes stop mid-tile
         count = grid_size - grid_pos + $urandom_range(0, 2) * grid_size;
         if ($urandom_range(0, 99) < 30) count = $urandom_range(1, count);

         if (phase == 0 || $urandom_range(0, 99) < 25) begin
            half = count / 2;
            queue_random(half, density);
            wait_drained();
            queue_random(count - half, density);
         end else begin
            queue_random(count, density);
         end
         wait_idle();
         random_items += count;
         phase++;
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
